// ===== hdl/infix_to_postfix_converter_macros.svh =====
// Assertion helpers used by the converter's stack engine (i2p_back).
// Each macro expects signals named clk and arst_n in the calling scope.
`ifndef INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH
`define INFIX_TO_POSTFIX_CONVERTER_MACROS_SVH

// The expression holds at every clock edge outside reset.
`define I2P_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// The consequent holds in the same cycle as the antecedent.
`define I2P_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define I2P_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hdl/i2p_pkg.sv =====
`default_nettype none

package i2p_pkg;

	// Default depth of the operator stack.
	localparam int unsigned STACK_DEPTH_DEF = 32;

	// Depth of the command queue between front and back; a power of two.
	localparam int unsigned QUEUE_DEPTH = 4;

	// Operator stack entry codes.
	typedef enum logic [2:0] {
		CODE_OPEN = 3'd0,
		CODE_ADD  = 3'd1,
		CODE_SUB  = 3'd2,
		CODE_MUL  = 3'd3,
		CODE_DIV  = 3'd4,
		CODE_MOD  = 3'd5
	} stk_code_t;

	// Sticky status reported with every result.
	typedef enum logic [1:0] {
		ERR_NONE      = 2'd0,
		ERR_OVERFLOW  = 2'd1,
		ERR_UNMATCHED = 2'd2,
		ERR_UNCLOSED  = 2'd3
	} err_t;

	// What the back end has to do for one accepted character.
	typedef enum logic [2:0] {
		CMD_PASS,
		CMD_OPEN,
		CMD_CLOSE,
		CMD_OPER,
		CMD_END,
		CMD_NONE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] sym;
		stk_code_t code;
	} cmd_t;

	typedef struct packed {
		logic [7:0] ch;
		logic char_valid;
		err_t status;
	} res_t;

	function automatic logic [7:0] code_char(input stk_code_t code);
		logic [7:0] c;
		case (code)
			CODE_ADD: c = 8'h2B;
			CODE_SUB: c = 8'h2D;
			CODE_MUL: c = 8'h2A;
			CODE_DIV: c = 8'h2F;
			CODE_MOD: c = 8'h25;
			default:  c = 8'h28;
		endcase
		return c;
	endfunction

	function automatic logic [1:0] code_prec(input stk_code_t code);
		logic [1:0] p;
		case (code)
			CODE_ADD, CODE_SUB:           p = 2'd1;
			CODE_MUL, CODE_DIV, CODE_MOD: p = 2'd2;
			default:                      p = 2'd0;
		endcase
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/i2p_front.sv =====
`default_nettype none

module i2p_front (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire logic         in_end,
	input  wire logic [7:0]   in_sym,
	output logic              cmd_valid,
	input  wire logic         cmd_ready,
	output i2p_pkg::cmd_t     cmd
);
	import i2p_pkg::*;

	logic  cmd_v_s1;
	cmd_t  cmd_s1;
	cmd_t  cls;
	logic  accept;

	// Sort the character into the action the back end takes.
	always_comb begin
		cls.kind = CMD_NONE;
		cls.sym  = in_sym;
		cls.code = CODE_OPEN;
		if (in_end) begin
			cls.kind = CMD_END;
		end else if (in_sym inside {[8'h41:8'h5A], [8'h61:8'h7A], [8'h30:8'h39]}) begin
			cls.kind = CMD_PASS;
		end else begin
			case (in_sym)
				8'h28: cls.kind = CMD_OPEN;
				8'h29: cls.kind = CMD_CLOSE;
				8'h2B: begin
					cls.kind = CMD_OPER;
					cls.code = CODE_ADD;
				end
				8'h2D: begin
					cls.kind = CMD_OPER;
					cls.code = CODE_SUB;
				end
				8'h2A: begin
					cls.kind = CMD_OPER;
					cls.code = CODE_MUL;
				end
				8'h2F: begin
					cls.kind = CMD_OPER;
					cls.code = CODE_DIV;
				end
				8'h25: begin
					cls.kind = CMD_OPER;
					cls.code = CODE_MOD;
				end
				default: cls.kind = CMD_NONE;
			endcase
		end
	end

	assign in_ready = !cmd_v_s1 || cmd_ready;
	assign accept   = in_valid && in_ready;

	// Ignored characters are accepted and simply not forwarded.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_v_s1 <= 1'b0;
		end else if (accept) begin
			cmd_v_s1 <= (cls.kind != CMD_NONE);
		end else if (cmd_ready) begin
			cmd_v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cls;
		end
	end

	assign cmd_valid = cmd_v_s1;
	assign cmd       = cmd_s1;

endmodule

`default_nettype wire

// ===== hdl/i2p_queue.sv =====
`default_nettype none

module i2p_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire i2p_pkg::cmd_t wr_cmd,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output i2p_pkg::cmd_t      rd_cmd
);
	import i2p_pkg::*;

	localparam int unsigned QW = $clog2(QUEUE_DEPTH);

	cmd_t          entry_q [QUEUE_DEPTH];
	logic [QW-1:0] wr_ptr_q;
	logic [QW-1:0] rd_ptr_q;
	logic [QW:0]   fill_q;
	logic          push;
	logic          pop;

	assign wr_ready = (fill_q != (QW+1)'(QUEUE_DEPTH));
	assign rd_valid = (fill_q != '0);
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= wr_cmd;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/i2p_back.sv =====
`default_nettype none
`include "infix_to_postfix_converter_macros.svh"

module i2p_back #(
	parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire i2p_pkg::cmd_t cmd,
	output logic               out_valid,
	input  wire logic          out_ready,
	output i2p_pkg::res_t      out_res,
	output logic               out_last
);
	import i2p_pkg::*;

	localparam int unsigned AW = $clog2(STACK_DEPTH);
	localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

	// Operator stack; written on push, read one below the top on pop.
	stk_code_t     stack_mem [STACK_DEPTH];
	stk_code_t     rd_q;
	stk_code_t     top_q;
	logic          top_mem_q;
	logic [CW-1:0] cnt_q;
	err_t          err_q;

	// Newest result of the current command, held until we know if it is the last.
	res_t          pend_q;
	logic          pend_valid_q;

	res_t          out_q;
	logic          out_last_q;
	logic          out_valid_q;

	stk_code_t     top;
	logic          has;
	logic          full;
	logic          out_free;
	logic          step_ok;
	logic [CW-1:0] below_ptr;

	logic          go;
	logic          fire;
	logic          done;
	logic          do_pop;
	logic          do_push;
	logic          set_err;
	err_t          err_new;
	logic          err_clr;
	logic          produce;
	res_t          prod;
	logic          flush;
	logic          ld_out;
	res_t          out_d;
	logic          out_last_d;
	logic          marker;
	logic          pend_clr;

	assign top       = top_mem_q ? rd_q : top_q;
	assign has       = (cnt_q != '0);
	assign full      = (cnt_q == CW'(STACK_DEPTH));
	assign out_free  = !out_valid_q || out_ready;
	assign step_ok   = !pend_valid_q || out_free;
	assign below_ptr = cnt_q - CW'(2);

	always_comb begin
		go       = 1'b0;
		done     = 1'b0;
		do_pop   = 1'b0;
		do_push  = 1'b0;
		set_err  = 1'b0;
		err_new  = ERR_NONE;
		err_clr  = 1'b0;
		produce  = 1'b0;
		prod     = '{ch: code_char(top), char_valid: 1'b1, status: err_q};
		flush    = 1'b0;
		marker   = 1'b0;
		pend_clr = 1'b0;
		case (cmd.kind)
			CMD_PASS: begin
				go   = out_free;
				done = 1'b1;
			end
			CMD_OPEN: begin
				go      = 1'b1;
				do_push = 1'b1;
				done    = 1'b1;
			end
			CMD_CLOSE: begin
				if (!has) begin
					go      = step_ok;
					set_err = 1'b1;
					err_new = ERR_UNMATCHED;
					flush   = 1'b1;
					done    = 1'b1;
				end else if (top == CODE_OPEN) begin
					go     = step_ok;
					do_pop = 1'b1;
					flush  = 1'b1;
					done   = 1'b1;
				end else begin
					go      = step_ok;
					do_pop  = 1'b1;
					produce = 1'b1;
				end
			end
			CMD_OPER: begin
				if (has && top != CODE_OPEN && code_prec(top) >= code_prec(cmd.code)) begin
					go      = step_ok;
					do_pop  = 1'b1;
					produce = 1'b1;
				end else begin
					go      = step_ok;
					do_push = 1'b1;
					flush   = 1'b1;
					done    = 1'b1;
				end
			end
			CMD_END: begin
				if (has) begin
					do_pop = 1'b1;
					if (top == CODE_OPEN) begin
						go      = 1'b1;
						set_err = 1'b1;
						err_new = ERR_UNCLOSED;
					end else begin
						go      = step_ok;
						produce = 1'b1;
					end
				end else if (pend_valid_q) begin
					go       = out_free;
					pend_clr = 1'b1;
				end else begin
					go      = out_free;
					marker  = 1'b1;
					err_clr = 1'b1;
					done    = 1'b1;
				end
			end
			default: begin
				go   = 1'b1;
				done = 1'b1;
			end
		endcase
	end

	assign fire      = cmd_valid && go;
	assign cmd_ready = go && done;

	// Select what moves into the output register in this step.
	always_comb begin
		ld_out     = 1'b0;
		out_d      = pend_q;
		out_last_d = 1'b0;
		if (cmd.kind == CMD_PASS) begin
			ld_out = 1'b1;
			out_d  = '{ch: cmd.sym, char_valid: 1'b1, status: err_q};
			out_last_d = 1'b1;
		end else if (marker) begin
			ld_out = 1'b1;
			out_d  = '{ch: 8'h00, char_valid: 1'b0, status: err_q};
			out_last_d = 1'b1;
		end else if ((produce || pend_clr) && pend_valid_q) begin
			ld_out = 1'b1;
		end else if (flush && pend_valid_q) begin
			ld_out     = 1'b1;
			out_last_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			err_q        <= ERR_NONE;
			top_mem_q    <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (fire && ld_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (fire) begin
				if (produce) begin
					pend_valid_q <= 1'b1;
				end else if (flush || pend_clr) begin
					pend_valid_q <= 1'b0;
				end
				if (do_pop) begin
					cnt_q     <= cnt_q - 1'b1;
					top_mem_q <= 1'b1;
				end else if (do_push && !full) begin
					cnt_q     <= cnt_q + 1'b1;
					top_mem_q <= 1'b0;
				end
				if (err_clr) begin
					err_q <= ERR_NONE;
				end else if ((set_err || (do_push && full)) && err_q == ERR_NONE) begin
					err_q <= set_err ? err_new : ERR_OVERFLOW;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_push && !full) begin
			stack_mem[cnt_q[AW-1:0]] <= cmd.code;
			top_q <= cmd.code;
		end
		if (fire && do_pop) begin
			rd_q <= stack_mem[below_ptr[AW-1:0]];
		end
		if (fire && produce) begin
			pend_q <= prod;
		end
		if (fire && ld_out) begin
			out_q      <= out_d;
			out_last_q <= out_last_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_last  = out_last_q;

	`I2P_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(STACK_DEPTH), "stack count above depth")
	`I2P_ASSERT_IMPLY(a_pop_nonempty, fire && do_pop, has, "pop from an empty stack")
	`I2P_ASSERT_NEXT(a_err_sticky, err_q != ERR_NONE && !(fire && err_clr), $stable(err_q), "held error replaced")
	`I2P_ASSERT_NEXT(a_end_clears, fire && marker, !has && err_q == ERR_NONE && !pend_valid_q, "end item left state behind")

endmodule

`default_nettype wire

// ===== hdl/infix_to_postfix_converter.sv =====
// Infix-to-postfix converter. Characters of an infix expression enter on the s_axis
// stream one per transaction and the postfix form leaves on m_axis. Letters and digits
// pass through, parentheses and the operators + - * / % are reordered through an operator
// stack of STACK_DEPTH entries, and every other byte is accepted and dropped. A transaction
// with tuser set ends the expression: the stack is flushed and an end marker (tuser 0,
// character 0) closes the output, carrying the final status; then the status is cleared.
// Every result carries the status held when it was produced (0 ok, 1 stack overflow,
// 2 unmatched close paren, 3 unclosed open paren); only the first error of an expression
// is kept. tlast marks the final result caused by an input character.
// Structure: a front stage classifies characters and a four-entry command queue feeds the
// stack engine, so input keeps flowing while the engine pops. The engine does one stack
// push or pop per cycle while its output can take results: a letter, digit or '(' needs
// no pop, an operator pops each operator of equal or higher precedence above the last '(',
// a ')' pops operators down to its '(', and an end item pops every stack entry before
// the end marker goes out.

`default_nettype none

module infix_to_postfix_converter #(
	parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input stream.
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [7:0]  s_axis_tdata,   // [7:0] symbol
	input  wire logic        s_axis_tuser,   // [0] op: 1 = end of expression
	// Output stream.
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [15:0]      m_axis_tdata,   // [7:0] out_char, [9:8] status, rest zero
	output logic             m_axis_tuser,   // [0] char_valid
	output logic             m_axis_tlast    // last result of the input character
);
	import i2p_pkg::*;

	// Classified command from the front stage into the queue.
	logic  f_valid;
	logic  f_ready;
	cmd_t  f_cmd;

	// Queue head into the stack engine.
	logic  q_valid;
	logic  q_ready;
	cmd_t  q_cmd;

	res_t  res;

	i2p_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_end    (s_axis_tuser),
		.in_sym    (s_axis_tdata),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.cmd       (f_cmd)
	);

	i2p_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_ready (f_ready),
		.wr_cmd   (f_cmd),
		.rd_valid (q_valid),
		.rd_ready (q_ready),
		.rd_cmd   (q_cmd)
	);

	// The engine owns the stack, the status and the output register.
	i2p_back #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {6'b000000, res.status, res.ch};
	assign m_axis_tuser = res.char_valid;

endmodule

`default_nettype wire
